/* hw/rtl/upp_pkg.sv */
// shared types, character codes and helper functions for the urlencoded pair parser
// no dependencies; imported by upp_step and urlencoded_pair_parser_unit
package upp_pkg;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_MISSING   = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_INVALID   = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_BAD_HEX   = 3'd5;

	// escape progress after '%'
	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_HI   = 2'd2;
	localparam logic [1:0] ESC_BAD  = 2'd3;

	typedef struct packed {
		logic       value_phase;
		logic       token_start;
		logic       message_started;
		logic [1:0] escape_digits;
		logic [3:0] high_nibble;
		logic [2:0] pending_key_error;
		logic [2:0] latched_status;
	} state_t;

	localparam state_t STATE_RESET = '{
		value_phase:       1'b0,
		token_start:       1'b1,
		message_started:   1'b0,
		escape_digits:     ESC_NONE,
		high_nibble:       4'd0,
		pending_key_error: ST_OK,
		latched_status:    ST_OK
	};

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       in_value;
		logic       pair_end;
		logic       done_res;
		logic [2:0] status;
	} res_t;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic state_t clear_token(input state_t s);
		state_t o;
		o = s;
		o.value_phase       = 1'b0;
		o.token_start       = 1'b1;
		o.escape_digits     = ESC_NONE;
		o.high_nibble       = 4'd0;
		o.pending_key_error = ST_OK;
		return o;
	endfunction

	// close the current token, returns 1 when the pair is accepted
	function automatic logic end_token(input state_t s, output state_t o);
		logic acc;
		o = s;
		acc = 1'b0;
		priority if (s.token_start) begin
			o.latched_status = ST_EMPTY;
		end else if (!s.value_phase) begin
			o.latched_status = ST_INVALID;
		end else if (s.escape_digits != ESC_NONE) begin
			o.latched_status = ST_TRUNCATED;
		end else begin
			o = clear_token(s);
			acc = 1'b1;
		end
		return acc;
	endfunction

endpackage

/* hw/rtl/upp_step.sv */
// combinational decode of one payload byte: next parser state and the result it causes
// depends on upp_pkg
module upp_step (
	input  logic [7:0]      in_byte,
	input  logic            has_byte,
	input  logic            last,
	input  upp_pkg::state_t state_cur,
	output upp_pkg::state_t state_nxt,
	output logic            emit,
	output upp_pkg::res_t   res
);
	import upp_pkg::*;

	logic [4:0] hv;
	state_t     n;
	state_t     t;
	logic       acc;

	assign hv = hex_value(in_byte);

	always_comb begin
		n   = state_cur;
		t   = state_cur;
		acc = 1'b0;
		res = '0;
		emit = 1'b0;

		if (has_byte && state_cur.latched_status == ST_OK) begin
			n.message_started = 1'b1;
			if (in_byte == CH_AMP) begin
				acc = end_token(state_cur, t);
				n = t;
				if (acc) begin
					res.pair_end = 1'b1;
					emit = 1'b1;
				end
			end else if (in_byte == CH_EQ && !state_cur.value_phase) begin
				priority if (state_cur.token_start) begin
					n.latched_status = ST_INVALID;
				end else if (state_cur.pending_key_error != ST_OK) begin
					n.latched_status = state_cur.pending_key_error;
				end else if (state_cur.escape_digits != ESC_NONE) begin
					n.latched_status = ST_TRUNCATED;
				end else begin
					n.value_phase = 1'b1;
					n.escape_digits = ESC_NONE;
				end
			end else begin
				n.token_start = 1'b0;
				priority if (!state_cur.value_phase && state_cur.pending_key_error != ST_OK) begin
					// key already failed, drop the byte
				end else if (state_cur.escape_digits == ESC_PCT) begin
					if (hv[4]) begin
						n.high_nibble = hv[3:0];
						n.escape_digits = ESC_HI;
					end else begin
						n.escape_digits = ESC_BAD;
					end
				end else if (state_cur.escape_digits == ESC_HI ||
						state_cur.escape_digits == ESC_BAD) begin
					if (state_cur.escape_digits == ESC_BAD || !hv[4]) begin
						if (state_cur.value_phase) begin
							n.latched_status = ST_BAD_HEX;
						end else begin
							n.pending_key_error = ST_BAD_HEX;
						end
					end else begin
						res.out_byte = {state_cur.high_nibble, hv[3:0]};
						res.byte_valid = 1'b1;
						emit = 1'b1;
					end
					n.escape_digits = ESC_NONE;
				end else if (in_byte == CH_PCT) begin
					n.escape_digits = ESC_PCT;
				end else if (in_byte == CH_PLUS) begin
					res.out_byte = CH_SPACE;
					res.byte_valid = 1'b1;
					emit = 1'b1;
				end else begin
					res.out_byte = in_byte;
					res.byte_valid = 1'b1;
					emit = 1'b1;
				end
				res.in_value = res.byte_valid & state_cur.value_phase;
			end
		end

		if (last) begin
			if (n.latched_status == ST_OK) begin
				if (!n.message_started) begin
					n.latched_status = ST_MISSING;
				end else begin
					if (end_token(n, t)) begin
						res.pair_end = 1'b1;
					end
					n = t;
				end
			end
			res.done_res = 1'b1;
			res.status = n.latched_status;
			emit = 1'b1;
			n = STATE_RESET;
		end

		state_nxt = n;
	end

endmodule

/* hw/rtl/urlencoded_pair_parser_unit.sv */
// top level of the urlencoded pair parser: input register, parser state and result register
// depends on upp_pkg and upp_step

// Decodes a form-urlencoded payload streamed one byte per request and emits
// decoded key and value bytes, a pair-accepted mark, and on the request for the
// last item the final status. Each byte passes through the input register and
// then the result register; one byte is taken every cycle while the output
// does not stall, and the only loop is the parser state updated by the single
// decode stage. A byte that produces nothing (an '=' after a key, '%', the first
// hex digit of an escape or anything after an error) yields no result request.
// The output register stalls the decode stage only while a result waits and the sink is not ready.
module urlencoded_pair_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tuser,  // [0] has_byte
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
	output logic [2:0]  m_axis_tuser,  // [0] byte_valid, [1] in_value, [2] pair_end
	output logic        m_axis_tlast   // done_res
);
	import upp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;

	logic       valid_s2;
	res_t       res_s2;

	state_t     state_q;
	state_t     state_nxt;
	logic       emit;
	res_t       res;

	logic       out_free;
	logic       advance;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	upp_step u_step (
		.in_byte   (byte_s1),
		.has_byte  (has_s1),
		.last      (last_s1),
		.state_cur (state_q),
		.state_nxt (state_nxt),
		.emit      (emit),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				valid_s2 <= advance && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
		if (advance && emit) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2.status, res_s2.out_byte};
	assign m_axis_tuser  = {res_s2.pair_end, res_s2.in_value, res_s2.byte_valid};
	assign m_axis_tlast  = res_s2.done_res;

endmodule
